FILE: hdl/dssp_pkg.sv
// shared types, constants and coil tables for the dual stepper phase sequencer
package dssp_pkg;

  localparam int unsigned COUNT_W = 18;
  localparam int unsigned ANGLE_W = 17;
  localparam int unsigned TEETH_W = 8;
  localparam int unsigned SPR_W   = 13;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned JOG_STEPS_DEFAULT = 10000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // teeth * angle * spr / (360 * 256): the 2^11 part is a shift, the 45 is a reciprocal
  localparam int unsigned PROD_A_W = TEETH_W + ANGLE_W;
  localparam int unsigned PROD_B_W = PROD_A_W + SPR_W;
  localparam int unsigned DIV_SHIFT = 11;
  localparam int unsigned SHIFTED_W = PROD_B_W - DIV_SHIFT;
  localparam int unsigned X_W = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd45);
  localparam logic [X_W-1:0] DIVISOR = X_W'(45);
  localparam logic [SHIFTED_W-1:0] SAT_LIMIT = SHIFTED_W'(262144 * 45);

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_JOG    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd4;

  localparam logic [1:0] MODE_CANCELLED = 2'd0;
  localparam logic [1:0] MODE_RUNNING   = 2'd1;
  localparam logic [1:0] MODE_PAUSED    = 2'd2;

  localparam logic [CFG_W-1:0] REG_HALF_STEP = 2'd0;
  localparam logic [CFG_W-1:0] REG_PAN_TEETH = 2'd1;
  localparam logic [CFG_W-1:0] REG_TILT_TEETH = 2'd2;
  localparam logic [CFG_W-1:0] REG_STEPS_PER_REV = 2'd3;

  localparam logic [TEETH_W-1:0] PAN_TEETH_RESET  = 8'd40;
  localparam logic [TEETH_W-1:0] TILT_TEETH_RESET = 8'd56;
  localparam logic [SPR_W-1:0]   SPR_RESET        = 13'd2048;
  localparam logic [7:0]         COIL_RESET       = 8'h11;

  typedef struct packed {
    logic apply_simple;
    logic load_op;
    logic mul2;
    logic recip;
    logic finish;
  } dssp_ctl_t;

  function automatic logic [3:0] coil_row(input logic half, input logic [2:0] p);
    logic [3:0] row;
    row = 4'h0;
    if (half) begin
      unique case (p)
        3'd0: row = 4'h1;
        3'd1: row = 4'h3;
        3'd2: row = 4'h2;
        3'd3: row = 4'h6;
        3'd4: row = 4'h4;
        3'd5: row = 4'hC;
        3'd6: row = 4'h8;
        3'd7: row = 4'h9;
      endcase
    end else begin
      unique case (p[1:0])
        2'd0: row = 4'h3;
        2'd1: row = 4'h6;
        2'd2: row = 4'hC;
        2'd3: row = 4'h9;
      endcase
    end
    return row;
  endfunction

endpackage

FILE: hdl/dssp_ctrl.sv
// controller state machine: handshakes and sequencing of the start-move arithmetic
module dssp_ctrl import dssp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output dssp_ctl_t        ctl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL2  = 2'd1;
  localparam logic [1:0] ST_RECIP = 2'd2;
  localparam logic [1:0] ST_CORR  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       accept;

  // the result slot is free or drains at this edge
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_START) begin
            ctl.load_op = 1'b1;
            state_next  = ST_MUL2;
          end else begin
            ctl.apply_simple = 1'b1;
          end
        end
      end
      ST_MUL2: begin
        ctl.mul2   = 1'b1;
        state_next = ST_RECIP;
      end
      ST_RECIP: begin
        ctl.recip  = 1'b1;
        state_next = ST_CORR;
      end
      ST_CORR: begin
        ctl.finish = 1'b1;
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = (out_valid && !out_ready) || ctl.apply_simple || ctl.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hdl/dssp_datapath.sv
// datapath: configuration, motion state, step-count arithmetic and result register
module dssp_datapath import dssp_pkg::*; #(
  parameter int unsigned JOG_STEPS = JOG_STEPS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dssp_ctl_t             ctl,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      cmd,
  input  logic                  motor_select,
  input  logic                  reverse_dir,
  input  logic [ANGLE_W-1:0]    angle_q8,
  output logic [7:0]            coil_pattern,
  output logic                  moving,
  output logic [COUNT_W-1:0]    steps_left
);

  logic               half_step_mode;
  logic [TEETH_W-1:0] pan_gear_teeth;
  logic [TEETH_W-1:0] tilt_gear_teeth;
  logic [SPR_W-1:0]   rev_steps;

  logic [2:0]         phase0, phase0_next;
  logic [2:0]         phase1, phase1_next;
  logic [7:0]         coil_latch, coil_next;
  logic [COUNT_W-1:0] step_count, count_next;
  logic               active_motor, active_next;
  logic               direction_flag, direction_next;
  logic [1:0]         run_mode, mode_next;

  logic                 op_msel;
  logic                 op_rev;
  logic [PROD_A_W-1:0]  prod_a;
  logic [PROD_B_W-1:0]  prod_b;
  logic [X_W-1:0]       x_lo;
  logic                 sat;
  logic [COUNT_W-1:0]   quot_est;

  logic [TEETH_W-1:0]          teeth_sel;
  logic [SHIFTED_W-1:0]        shifted;
  logic [X_W+RECIP_W-1:0]      recip_prod;
  logic [X_W-1:0]              back_prod;
  logic [X_W-1:0]              remainder;
  logic [COUNT_W-1:0]          start_count;
  logic [2:0]                  phase_cur, phase_new;
  logic [3:0]                  row;
  logic                        moving_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode  <= 1'b0;
      pan_gear_teeth  <= PAN_TEETH_RESET;
      tilt_gear_teeth <= TILT_TEETH_RESET;
      rev_steps       <= SPR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_STEP:     half_step_mode  <= cfg_data[0];
        REG_PAN_TEETH:     pan_gear_teeth  <= cfg_data[TEETH_W-1:0];
        REG_TILT_TEETH:    tilt_gear_teeth <= cfg_data[TEETH_W-1:0];
        REG_STEPS_PER_REV: rev_steps       <= cfg_data;
      endcase
    end
  end

  // step count arithmetic, one stage per controller step
  assign teeth_sel = motor_select ? tilt_gear_teeth : pan_gear_teeth;
  assign shifted   = prod_b[PROD_B_W-1:DIV_SHIFT];
  assign recip_prod = {{RECIP_W{1'b0}}, shifted[X_W-1:0]} * {{X_W{1'b0}}, RECIP_M};
  assign back_prod = {{(X_W-COUNT_W){1'b0}}, quot_est} * DIVISOR;
  assign remainder = x_lo - back_prod;

  // estimate is low by at most one
  always_comb begin
    if (sat) begin
      start_count = COUNT_MAX;
    end else if (remainder >= DIVISOR) begin
      start_count = quot_est + COUNT_W'(1);
    end else begin
      start_count = quot_est;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_op) begin
      op_msel <= motor_select;
      op_rev  <= reverse_dir;
      prod_a  <= {{ANGLE_W{1'b0}}, teeth_sel} * {{TEETH_W{1'b0}}, angle_q8};
    end
    if (ctl.mul2) begin
      prod_b <= {{SPR_W{1'b0}}, prod_a} * {{PROD_A_W{1'b0}}, rev_steps};
    end
    if (ctl.recip) begin
      x_lo     <= shifted[X_W-1:0];
      sat      <= (shifted >= SAT_LIMIT);
      quot_est <= recip_prod[RECIP_SHIFT+COUNT_W-1:RECIP_SHIFT];
    end
  end

  // one phase step of the active motor
  assign phase_cur = active_motor ? phase1 : phase0;
  assign phase_new = direction_flag ? phase_cur + 3'd1 : phase_cur - 3'd1;
  assign row       = coil_row(half_step_mode, phase_new);

  always_comb begin
    phase0_next    = phase0;
    phase1_next    = phase1;
    coil_next      = coil_latch;
    count_next     = step_count;
    active_next    = active_motor;
    direction_next = direction_flag;
    mode_next      = run_mode;
    if (ctl.apply_simple) begin
      unique case (cmd)
        CMD_TICK: begin
          if (run_mode == MODE_RUNNING && step_count != '0) begin
            count_next = step_count - COUNT_W'(1);
            if (active_motor) begin
              phase1_next = phase_new;
              coil_next   = {row, coil_latch[3:0]};
            end else begin
              phase0_next = phase_new;
              coil_next   = {coil_latch[7:4], row};
            end
          end
        end
        CMD_JOG: begin
          count_next     = COUNT_W'(JOG_STEPS);
          active_next    = motor_select;
          direction_next = reverse_dir;
          mode_next      = MODE_RUNNING;
        end
        CMD_PAUSE: begin
          if (run_mode == MODE_RUNNING) begin
            mode_next = MODE_PAUSED;
          end
        end
        CMD_CANCEL: begin
          mode_next = MODE_CANCELLED;
        end
        default: begin
        end
      endcase
    end else if (ctl.finish) begin
      count_next     = start_count;
      active_next    = op_msel;
      direction_next = op_rev;
      mode_next      = MODE_RUNNING;
    end
  end

  assign moving_next = (count_next != '0) && (mode_next != MODE_CANCELLED);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase0         <= 3'd0;
      phase1         <= 3'd0;
      coil_latch     <= COIL_RESET;
      step_count     <= '0;
      active_motor   <= 1'b0;
      direction_flag <= 1'b0;
      run_mode       <= MODE_CANCELLED;
    end else begin
      phase0         <= phase0_next;
      phase1         <= phase1_next;
      coil_latch     <= coil_next;
      step_count     <= count_next;
      active_motor   <= active_next;
      direction_flag <= direction_next;
      run_mode       <= mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.apply_simple || ctl.finish) begin
      coil_pattern <= coil_next;
      moving       <= moving_next;
      steps_left   <= count_next;
    end
  end

endmodule

FILE: hdl/dual_stepper_phase_sequencer_core.sv
// top level of the dual unipolar stepper phase sequencer
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//  input     in_valid / in_ready    cmd, motor_select, reverse_dir, angle_q8
//  output    out_valid / out_ready  coil_pattern, moving, steps_left
//
// tick, jog, pause and cancel apply when accepted; a start move runs the load, multiply,
// reciprocal and correction states of the two-multiply, reciprocal-divide step count.
// one item in flight at a time; input is taken while a result waits if that result
// is taken in the same cycle.
// synchronous reset clears the motion state and loads the default gear registers.
// config writes are always accepted.
module dual_stepper_phase_sequencer_core import dssp_pkg::*; #(
  parameter int unsigned JOG_STEPS = JOG_STEPS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      cmd,
  input  logic                  motor_select,
  input  logic                  reverse_dir,
  input  logic [ANGLE_W-1:0]    angle_q8,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            coil_pattern,
  output logic                  moving,
  output logic [COUNT_W-1:0]    steps_left
);

  dssp_ctl_t ctl;

  assign cfg_ready = 1'b1;

  dssp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  dssp_datapath #(
    .JOG_STEPS (JOG_STEPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .motor_select (motor_select),
    .reverse_dir  (reverse_dir),
    .angle_q8     (angle_q8),
    .coil_pattern (coil_pattern),
    .moving       (moving),
    .steps_left   (steps_left)
  );

endmodule

FILE: bench/tb_dual_stepper_phase_sequencer_core.sv
// testbench for the dual stepper phase sequencer core: random traffic, predicted and checked
`timescale 1ns / 1ps

module tb_dual_stepper_phase_sequencer_core;
  import dssp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int MOVES_PER_PHASE = 180;
  localparam int ANGLE_FULL_TURN = 92160;

  typedef struct packed {
    logic [7:0]         coils;
    logic               moving;
    logic [COUNT_W-1:0] steps;
  } coil_result_t;

  // tracks both motors and the active move, keeps the results still owed by the block
  class coil_scoreboard;
    logic               half_mode;
    logic [7:0]         pan_teeth;
    logic [7:0]         tilt_teeth;
    logic [SPR_W-1:0]   rev_steps;
    logic [2:0]         phase [2];
    logic [7:0]         coils;
    logic [COUNT_W-1:0] count;
    logic               motor;
    logic               dir;
    logic [1:0]         mode;
    coil_result_t       pending_outputs [$];
    int                 mismatches;
    int                 results_seen;

    function new();
      half_mode = 1'b0;
      pan_teeth = PAN_TEETH_RESET;
      tilt_teeth = TILT_TEETH_RESET;
      rev_steps = SPR_RESET;
      phase[0] = 3'd0;
      phase[1] = 3'd0;
      coils = COIL_RESET;
      count = '0;
      motor = 1'b0;
      dir = 1'b0;
      mode = MODE_CANCELLED;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HALF_STEP:     half_mode = data[0];
        REG_PAN_TEETH:     pan_teeth = data[7:0];
        REG_TILT_TEETH:    tilt_teeth = data[7:0];
        REG_STEPS_PER_REV: rev_steps = data;
        default: ;
      endcase
    endfunction

    // one nibble per phase, phase 0 in the low nibble
    function logic [3:0] row_at(logic [2:0] p);
      logic [31:0] rows;
      rows = half_mode ? 32'h98C46231 : 32'h9C639C63;
      return rows[p*4 +: 4];
    endfunction

    function logic [COUNT_W-1:0] steps_for(logic m, logic [ANGLE_W-1:0] angle);
      longint unsigned teeth;
      longint unsigned product;
      longint unsigned quotient;
      teeth = m ? tilt_teeth : pan_teeth;
      product = teeth * angle * rev_steps;
      quotient = product / ANGLE_FULL_TURN;
      if (quotient > COUNT_MAX) return COUNT_MAX;
      return quotient[COUNT_W-1:0];
    endfunction

    function void step_motor();
      logic [2:0] p;
      p = phase[motor];
      p = dir ? p + 3'd1 : p - 3'd1;
      phase[motor] = p;
      if (motor) coils[7:4] = row_at(p);
      else coils[3:0] = row_at(p);
    endfunction

    function void note_input(logic [CMD_W-1:0] c, logic m, logic d, logic [ANGLE_W-1:0] a);
      coil_result_t want;
      case (c)
        CMD_TICK: begin
          if (mode == MODE_RUNNING && count != 0) begin
            count = count - 1'b1;
            step_motor();
          end
        end
        CMD_START: begin
          count = steps_for(m, a);
          motor = m;
          dir = d;
          mode = MODE_RUNNING;
        end
        CMD_JOG: begin
          count = COUNT_W'(JOG_STEPS_DEFAULT);
          motor = m;
          dir = d;
          mode = MODE_RUNNING;
        end
        CMD_PAUSE: begin
          if (mode == MODE_RUNNING) mode = MODE_PAUSED;
        end
        CMD_CANCEL: mode = MODE_CANCELLED;
        default: ;
      endcase
      want.coils = coils;
      want.moving = (count != 0) && (mode != MODE_CANCELLED);
      want.steps = count;
      pending_outputs.insert(pending_outputs.size(), want);
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task check_result(logic [7:0] coils_seen, logic moving_seen,
                      logic [COUNT_W-1:0] steps_seen);
      coil_result_t want;
      if (pending_outputs.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = pending_outputs.pop_front();
        if (coils_seen !== want.coils)
          report($sformatf("coil_pattern %h, expected %h", coils_seen, want.coils));
        if (moving_seen !== want.moving)
          report($sformatf("moving %b, expected %b", moving_seen, want.moving));
        if (steps_seen !== want.steps)
          report($sformatf("steps_left %0d, expected %0d", steps_seen, want.steps));
      end
      results_seen++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      cmd;
  logic                  motor_select;
  logic                  reverse_dir;
  logic [ANGLE_W-1:0]    angle_q8;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            coil_pattern;
  logic                  moving;
  logic [COUNT_W-1:0]    steps_left;

  coil_scoreboard sb;
  int cycle_count;
  int items_sent;
  int holds_asked;
  int holds_done;
  int send_calm;

  dual_stepper_phase_sequencer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .motor_select (motor_select),
    .reverse_dir  (reverse_dir),
    .angle_q8     (angle_q8),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .coil_pattern (coil_pattern),
    .moving       (moving),
    .steps_left   (steps_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_dual_stepper_phase_sequencer_core failed");
      $finish;
    end
  end

  // wait before a transfer: mostly drawn at random, now and then a stretch with none
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return ANGLE_W'($urandom_range(0, 63));
    if (r < 95) return ANGLE_W'($urandom_range(0, ANGLE_FULL_TURN));
    return ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1));
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] c, input logic m, input logic d,
                           input logic [ANGLE_W-1:0] a);
    int gap;
    gap = draw_wait(send_calm);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = c;
    motor_select = m;
    reverse_dir = d;
    angle_q8 = a;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(c, m, d, a);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] half, input logic [CFG_DATA_W-1:0] pan,
                           input logic [CFG_DATA_W-1:0] tilt, input logic [CFG_DATA_W-1:0] spr);
    write_reg(REG_HALF_STEP, half);
    write_reg(REG_PAN_TEETH, pan);
    write_reg(REG_TILT_TEETH, tilt);
    write_reg(REG_STEPS_PER_REV, spr);
  endtask

  // moves: a start, jog or cancel, then a burst of ticks with pauses, cancels and junk mixed in
  task automatic run_moves(input int target);
    int stop_at;
    int ticks;
    int r;
    logic [CMD_W-1:0] c;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) c = CMD_START;
      else if (r < 90) c = CMD_JOG;
      else c = CMD_CANCEL;
      send_item(c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_angle());
      ticks = $urandom_range(0, 40);
      repeat (ticks) begin
        r = $urandom_range(0, 99);
        if (r < 4) c = CMD_PAUSE;
        else if (r < 7) c = CMD_CANCEL;
        else if (r < 10) c = CMD_W'($urandom_range(5, 7));
        else c = CMD_TICK;
        send_item(c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1)));
      end
    end
  endtask

  task automatic directed_basics();
    send_item(CMD_TICK, 1'b0, 1'b0, '0);
    send_item(CMD_PAUSE, 1'b0, 1'b0, '0);
    send_item(CMD_W'(5), 1'b1, 1'b1, '1);
    send_item(CMD_W'(6), 1'b0, 1'b1, '0);
    send_item(CMD_W'(7), 1'b1, 1'b0, '1);
    send_item(CMD_START, 1'b1, 1'b0, '0);
    // 2/256 of a degree gives a single step
    send_item(CMD_START, 1'b0, 1'b0, ANGLE_W'(2));
    send_item(CMD_TICK, 1'b0, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, 1'b0, '0);
    send_item(CMD_JOG, 1'b1, 1'b1, '0);
    repeat (3) send_item(CMD_TICK, 1'b1, 1'b1, '1);
    send_item(CMD_PAUSE, 1'b0, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, 1'b0, '0);
    send_item(CMD_START, 1'b0, 1'b1, '1);
    send_item(CMD_TICK, 1'b0, 1'b0, '0);
    send_item(CMD_CANCEL, 1'b0, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, 1'b0, '0);
    send_item(CMD_START, 1'b1, 1'b0, ANGLE_W'(ANGLE_FULL_TURN));
  endtask

  initial begin : result_sink
    int wait_cycles;
    int calm;
    out_ready = 1'b0;
    calm = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_done < holds_asked) begin
        // long stall so the core backs up and blocks its input
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      wait_cycles = draw_wait(calm);
      if (wait_cycles != 0) begin
        out_ready = 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(coil_pattern, moving, steps_left);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int ph;
    sb = new();
    items_sent = 0;
    holds_asked = 0;
    holds_done = 0;
    send_calm = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_TICK;
    motor_select = 1'b0;
    reverse_dir = 1'b0;
    angle_q8 = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: begin
          directed_basics();
          run_moves(MOVES_PER_PHASE / 2);
          holds_asked++;
          run_moves(MOVES_PER_PHASE / 2);
        end
        1: begin
          write_all(1, 1, 255, 1);
          run_moves(MOVES_PER_PHASE);
        end
        2: begin
          // widest product, count saturates
          write_all(1, 255, 255, 8191);
          send_item(CMD_START, 1'b0, 1'b1, '1);
          send_item(CMD_TICK, 1'b0, 1'b0, '0);
          send_item(CMD_START, 1'b1, 1'b0, '1);
          run_moves(MOVES_PER_PHASE);
        end
        3: begin
          // zero gear teeth gives no steps
          write_all(0, 0, 1, 4096);
          send_item(CMD_START, 1'b0, 1'b0, ANGLE_W'(ANGLE_FULL_TURN));
          send_item(CMD_TICK, 1'b0, 1'b0, '0);
          run_moves(MOVES_PER_PHASE);
        end
        default: begin
          write_all(CFG_DATA_W'($urandom_range(0, 8191)), CFG_DATA_W'($urandom_range(0, 8191)),
                    CFG_DATA_W'($urandom_range(0, 8191)), CFG_DATA_W'($urandom_range(1, 8191)));
          run_moves(MOVES_PER_PHASE);
        end
      endcase
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_dual_stepper_phase_sequencer_core passed");
    end else begin
      $display("tb_dual_stepper_phase_sequencer_core failed");
    end
    $finish;
  end

endmodule
